// ===== design/ip_connection_limit_ban_table_defines.svh =====
// Assertion macros for the connection limit ban table
`ifndef IP_CONNECTION_LIMIT_BAN_TABLE_DEFINES_SVH
`define IP_CONNECTION_LIMIT_BAN_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define IPCLB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ipclb assertion failed");
`define IPCLB_ASSERT_NEVER(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("ipclb forbidden condition seen");
`else
`define IPCLB_ASSERT(label, prop)
`define IPCLB_ASSERT_NEVER(label, prop)
`endif

`endif

// ===== design/ipclb_pkg.sv =====
// Package: widths, register indexes, verdict codes, state and token types
package ipclb_pkg;

    localparam int BAN_ENTRIES_DEF  = 64;
    localparam int SAFE_ENTRIES_DEF = 4;

    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int SECONDS_W  = 16;
    localparam int SAFE_CNT_W = 3;
    localparam int VERDICT_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SAFE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_ADDR_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_ADDR_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_ADDR_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_ADDR_D = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BAN_SECONDS = 3'd6;

    localparam logic [COUNT_W-1:0]   LIMIT_RESET       = 16'd20;
    localparam logic [SECONDS_W-1:0] BAN_SECONDS_RESET = 16'd300;

    localparam logic [VERDICT_W-1:0] VERDICT_SAFE    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_UNDER   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_BANNED  = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_NEW_BAN = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // lookup token walking the cell row
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] peer;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] expiry;
        logic              ban;
        logic              hit;
        logic              slot_taken;
    } token_t;

    // end-of-scan broadcast: resolve tentative inserts
    typedef struct packed {
        logic fin;
        logic keep;
    } commit_t;

endpackage

// ===== design/ipclb_req_if.sv =====
// Request channel interface: one connection attempt per transfer
interface ipclb_req_if;
    import ipclb_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  peer_addr;
    logic [TIME_W-1:0]  now_seconds;
    logic [COUNT_W-1:0] open_count;

    modport source (output valid, output peer_addr, output now_seconds, output open_count,
                    input ready);
    modport sink (input valid, input peer_addr, input now_seconds, input open_count,
                  output ready);
endinterface

// ===== design/ipclb_res_if.sv =====
// Result channel interface: one decision per transfer
interface ipclb_res_if;
    import ipclb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 admit;
    logic [VERDICT_W-1:0] verdict;
    logic                 table_full;

    modport source (output valid, output admit, output verdict, output table_full,
                    input ready);
    modport sink (input valid, input admit, input verdict, input table_full,
                  output ready);
endinterface

// ===== design/ipclb_cfg_if.sv =====
// Configuration write channel interface
interface ipclb_cfg_if;
    import ipclb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/ip_connection_limit_ban_table.sv =====
// Top level: per-address connection limit with timed ban table
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    peer_addr, now_seconds, open_count
//  res      out  valid/ready    admit, verdict, table_full
//  cfg      in   valid/ready    index, data (ready always high)
//
// Safe-list hit: the verdict is registered in CHECK and moves to the output register in EMIT.
// Otherwise a lookup token walks the cell row, one entry per cycle; the verdict is registered
// from the token at the row's tail in SCAN and moves to the output register in EMIT.
// req.ready is high only in IDLE; a result waits in the output register while the next
// request runs, and EMIT stalls until that register is free.
// Reset clears all entry valid flags at once; no clearing pass.
`include "ip_connection_limit_ban_table_defines.svh"

module ip_connection_limit_ban_table #(
    parameter int BAN_ENTRIES  = ipclb_pkg::BAN_ENTRIES_DEF,
    parameter int SAFE_ENTRIES = ipclb_pkg::SAFE_ENTRIES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    ipclb_req_if.sink req,
    ipclb_res_if.source res,
    ipclb_cfg_if.sink cfg
);
    import ipclb_pkg::*;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]    peer_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [COUNT_W-1:0]   count_reg;

    logic [SAFE_CNT_W-1:0] safe_count_reg;
    logic [ADDR_W-1:0]     safe_addr_reg [SAFE_ENTRIES];
    logic [COUNT_W-1:0]    limit_reg;
    logic [SECONDS_W-1:0]  ban_sec_reg;

    logic                 stage_admit_reg, stage_admit_next;
    logic [VERDICT_W-1:0] stage_verdict_reg, stage_verdict_next;
    logic                 stage_full_reg, stage_full_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_admit_reg;
    logic [VERDICT_W-1:0] out_verdict_reg;
    logic                 out_full_reg;

    logic [SAFE_ENTRIES-1:0] safe_hit_vec;
    logic                    safe_hit;
    logic                    ban_now;
    logic [TIME_W:0]         expiry_sum;
    logic [TIME_W-1:0]       expiry_sat;
    logic                    req_xfer;
    logic                    cfg_xfer;
    logic                    out_load;
    logic                    verdict_admits;

    token_t                 tok [BAN_ENTRIES+1];
    token_t                 tok_head;
    token_t                 tail;
    commit_t                commit;
    logic [BAN_ENTRIES-1:0] tok_valid_vec;

    assign req_xfer = req.valid && req.ready;
    assign cfg_xfer = cfg.valid && cfg.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_count_reg <= '0;
            limit_reg      <= LIMIT_RESET;
            ban_sec_reg    <= BAN_SECONDS_RESET;
        end
        else if (cfg_xfer)
        begin
            case (cfg.index)
                REG_SAFE_COUNT:  safe_count_reg <= cfg.data[SAFE_CNT_W-1:0];
                REG_LIMIT:       limit_reg      <= cfg.data[COUNT_W-1:0];
                REG_BAN_SECONDS: ban_sec_reg    <= cfg.data[SECONDS_W-1:0];
                default:         ;
            endcase
        end
    end

    for (genvar g = 0; g < SAFE_ENTRIES; g++)
    begin : g_safe
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                safe_addr_reg[g] <= '0;
            end
            else if (cfg_xfer && (cfg.index == CFG_IDX_W'(int'(REG_SAFE_ADDR_A) + g)))
            begin
                safe_addr_reg[g] <= cfg.data[ADDR_W-1:0];
            end
        end

        assign safe_hit_vec[g] = (SAFE_CNT_W'(g) < safe_count_reg)
                                 && (safe_addr_reg[g] == peer_reg);
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            peer_reg  <= req.peer_addr;
            now_reg   <= req.now_seconds;
            count_reg <= req.open_count;
        end
    end

    always_comb
    begin
        safe_hit   = |safe_hit_vec;
        ban_now    = count_reg >= limit_reg;
        expiry_sum = {1'b0, now_reg} + (TIME_W+1)'(ban_sec_reg);
        expiry_sat = expiry_sum[TIME_W] ? '1 : expiry_sum[TIME_W-1:0];
    end

    // cell row
    always_comb
    begin
        tok_head        = '0;
        tok_head.valid  = (state_reg == ST_CHECK) && !safe_hit;
        tok_head.peer   = peer_reg;
        tok_head.now    = now_reg;
        tok_head.expiry = expiry_sat;
        tok_head.ban    = ban_now;
    end

    assign tok[0]      = tok_head;
    assign tail        = tok[BAN_ENTRIES];
    assign commit.fin  = tail.valid;
    assign commit.keep = !tail.hit;

    for (genvar g = 0; g < BAN_ENTRIES; g++)
    begin : g_cell
        ipclb_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[g]),
            .commit  (commit),
            .tok_out (tok[g+1])
        );

        assign tok_valid_vec[g] = tok[g+1].valid;
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = safe_hit ? ST_EMIT : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        stage_admit_next   = stage_admit_reg;
        stage_verdict_next = stage_verdict_reg;
        stage_full_next    = stage_full_reg;
        out_load           = 1'b0;
        case (state_reg)
            ST_CHECK:
            begin
                if (safe_hit)
                begin
                    stage_admit_next   = 1'b1;
                    stage_verdict_next = VERDICT_SAFE;
                    stage_full_next    = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    if (tail.hit)
                    begin
                        stage_admit_next   = 1'b0;
                        stage_verdict_next = VERDICT_BANNED;
                        stage_full_next    = 1'b0;
                    end
                    else if (tail.ban)
                    begin
                        stage_admit_next   = 1'b0;
                        stage_verdict_next = VERDICT_NEW_BAN;
                        stage_full_next    = !tail.slot_taken;
                    end
                    else
                    begin
                        stage_admit_next   = 1'b1;
                        stage_verdict_next = VERDICT_UNDER;
                        stage_full_next    = 1'b0;
                    end
                end
            end
            ST_EMIT:
            begin
                out_load = !out_valid_reg || res.ready;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_admit_reg   <= stage_admit_next;
        stage_verdict_reg <= stage_verdict_next;
        stage_full_reg    <= stage_full_next;
        if (out_load)
        begin
            out_admit_reg   <= stage_admit_reg;
            out_verdict_reg <= stage_verdict_reg;
            out_full_reg    <= stage_full_reg;
        end
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign res.valid      = out_valid_reg;
    assign res.admit      = out_admit_reg;
    assign res.verdict    = out_verdict_reg;
    assign res.table_full = out_full_reg;

    assign verdict_admits = (res.verdict == VERDICT_SAFE) || (res.verdict == VERDICT_UNDER);

    `IPCLB_ASSERT(a_full_new_ban, res.valid && res.table_full |-> res.verdict == VERDICT_NEW_BAN)
    `IPCLB_ASSERT(a_admit_verdict, res.valid |-> res.admit == verdict_admits)
    `IPCLB_ASSERT(a_one_token, $countones(tok_valid_vec) <= 1)
    `IPCLB_ASSERT_NEVER(a_tail_outside_scan, tail.valid && state_reg != ST_SCAN)

endmodule

// ===== design/ipclb_cell.sv =====
// One ban table entry; checks and forwards the lookup token each cycle
module ipclb_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  ipclb_pkg::token_t  tok_in,
    input  ipclb_pkg::commit_t commit,
    output ipclb_pkg::token_t  tok_out
);
    import ipclb_pkg::*;

    logic              valid_reg, valid_next;
    logic              pending_reg, pending_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [TIME_W-1:0] expiry_reg, expiry_next;
    token_t            tok_reg, tok_next;

    logic active;
    logic match;
    logic live;
    logic free_here;
    logic take;

    always_comb
    begin
        active    = tok_in.valid && !tok_in.hit;
        match     = valid_reg && (addr_reg == tok_in.peer);
        live      = (expiry_reg == '0) || (expiry_reg > tok_in.now);
        free_here = !valid_reg || (match && !live);
        take      = active && free_here && tok_in.ban && !tok_in.slot_taken;

        valid_next   = valid_reg;
        pending_next = pending_reg;
        addr_next    = addr_reg;
        expiry_next  = expiry_reg;
        tok_next     = tok_in;

        if (active && match && live)
        begin
            tok_next.hit = 1'b1;
        end
        if (active && match && !live)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            pending_next        = 1'b1;
            addr_next           = tok_in.peer;
            expiry_next         = tok_in.expiry;
            tok_next.slot_taken = 1'b1;
        end
        if (commit.fin)
        begin
            pending_next = 1'b0;
            if (pending_reg && commit.keep)
            begin
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
            tok_reg     <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
            tok_reg     <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        expiry_reg <= expiry_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== test/tb_top.sv =====
// Testbench for the connection limit ban table: queue-fed driver, checking monitor, predictor
`timescale 1ns / 100ps

module tb_top;
    import ipclb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int POOL_SIZE = 96;

    typedef struct packed {
        logic [ADDR_W-1:0]  peer;
        logic [TIME_W-1:0]  now;
        logic [COUNT_W-1:0] count;
    } attempt_t;

    typedef struct packed {
        logic                 admit;
        logic [VERDICT_W-1:0] verdict;
        logic                 table_full;
    } decision_t;

    logic clk = 1'b0;
    logic rst_n;

    ipclb_req_if req_ch();
    ipclb_res_if res_ch();
    ipclb_cfg_if cfg_ch();

    ip_connection_limit_ban_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor copy of registers and ban table
    logic [SAFE_CNT_W-1:0] safe_cnt_q;
    logic [ADDR_W-1:0]     safe_list [SAFE_ENTRIES_DEF];
    logic [COUNT_W-1:0]    limit_q;
    logic [SECONDS_W-1:0]  ban_len_q;
    logic [ADDR_W-1:0]     bt_addr   [BAN_ENTRIES_DEF];
    logic [TIME_W-1:0]     bt_expiry [BAN_ENTRIES_DEF];
    logic                  bt_used   [BAN_ENTRIES_DEF];

    attempt_t  attempt_queue[$];
    decision_t pending_verdicts[$];
    attempt_t  live_attempt;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    int issued_count = 0;
    int taken_count  = 0;
    int bad_results  = 0;
    int full_seen    = 0;
    int config_sets  = 1;
    int verdict_tally [4] = '{0, 0, 0, 0};

    int   burst_left;
    int   gap_left;
    logic drain_hold;
    int   rdy_mode;
    int   rdy_stall;
    int   rdy_tick;

    function automatic decision_t judge_attempt(attempt_t a);
        decision_t       d;
        int              n_safe;
        int              slot;
        logic [TIME_W:0] sum;
        d = '0;
        n_safe = (safe_cnt_q > SAFE_ENTRIES_DEF) ? SAFE_ENTRIES_DEF : int'(safe_cnt_q);
        for (int i = 0; i < n_safe; i++)
        begin
            if (safe_list[i] == a.peer)
            begin
                d.admit   = 1'b1;
                d.verdict = VERDICT_SAFE;
                return d;
            end
        end
        for (int i = 0; i < BAN_ENTRIES_DEF; i++)
        begin
            if (bt_used[i] && bt_addr[i] == a.peer)
            begin
                if (bt_expiry[i] == '0 || bt_expiry[i] > a.now)
                begin
                    d.verdict = VERDICT_BANNED;
                    return d;
                end
                bt_used[i] = 1'b0;
                break;
            end
        end
        if (a.count >= limit_q)
        begin
            sum  = {1'b0, a.now} + ban_len_q;
            slot = -1;
            for (int i = BAN_ENTRIES_DEF - 1; i >= 0; i--)
            begin
                if (!bt_used[i])
                    slot = i;
            end
            if (slot >= 0)
            begin
                bt_used[slot]   = 1'b1;
                bt_addr[slot]   = a.peer;
                bt_expiry[slot] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            end
            else
                d.table_full = 1'b1;
            d.verdict = VERDICT_NEW_BAN;
            return d;
        end
        d.admit   = 1'b1;
        d.verdict = VERDICT_UNDER;
        return d;
    endfunction

    task automatic queue_attempt(logic [ADDR_W-1:0] peer, logic [TIME_W-1:0] now,
                                 logic [COUNT_W-1:0] cnt);
        attempt_t a;
        a.peer  = peer;
        a.now   = now;
        a.count = cnt;
        attempt_queue = {attempt_queue, a};
        issued_count++;
    endtask

    // all queued attempts taken and every decision returned
    task automatic wait_idle();
        while (taken_count != issued_count || pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_SAFE_COUNT:  safe_cnt_q   = data[SAFE_CNT_W-1:0];
            REG_SAFE_ADDR_A: safe_list[0] = data;
            REG_SAFE_ADDR_B: safe_list[1] = data;
            REG_SAFE_ADDR_C: safe_list[2] = data;
            REG_SAFE_ADDR_D: safe_list[3] = data;
            REG_LIMIT:       limit_q      = data[COUNT_W-1:0];
            REG_BAN_SECONDS: ban_len_q    = data[SECONDS_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : attempt_driver
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.peer_addr   <= '0;
            req_ch.now_seconds <= '0;
            req_ch.open_count  <= '0;
            burst_left = 0;
            gap_left   = 0;
            drain_hold = 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                pending_verdicts = {pending_verdicts, judge_attempt(live_attempt)};
                taken_count++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (drain_hold && pending_verdicts.size() == 0)
                    drain_hold = 1'b0;
                if (gap_left > 0 || drain_hold || attempt_queue.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    live_attempt = attempt_queue.pop_front();
                    req_ch.peer_addr   <= live_attempt.peer;
                    req_ch.now_seconds <= live_attempt.now;
                    req_ch.open_count  <= live_attempt.count;
                    req_ch.valid       <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 7);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
                        // now and then hold off until the block has drained
                        drain_hold = ($urandom_range(0, 9) == 0);
                    end
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : verdict_monitor
        decision_t want;
        decision_t seen;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            rdy_mode  = 0;
            rdy_stall = 0;
            rdy_tick  = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                seen.admit      = res_ch.admit;
                seen.verdict    = res_ch.verdict;
                seen.table_full = res_ch.table_full;
                if (pending_verdicts.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("[%0t] ERROR: extra result %0d/%0d/%0d (admit/verdict/full)",
                                 $realtime, seen.admit, seen.verdict, seen.table_full);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (seen.admit !== want.admit || seen.verdict !== want.verdict ||
                        seen.table_full !== want.table_full)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display("[%0t] ERROR: admit/verdict/full exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, want.admit, want.verdict, want.table_full,
                                     seen.admit, seen.verdict, seen.table_full);
                    end
                    verdict_tally[seen.verdict]++;
                    if (seen.table_full)
                        full_seen++;
                end
            end
            rdy_tick++;
            if (rdy_tick % 700 == 0)
                rdy_mode = $urandom_range(0, 2);
            case (rdy_mode)
                0: res_ch.ready <= 1'b1;
                1:
                begin
                    if (rdy_stall > 0)
                    begin
                        rdy_stall--;
                        res_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        res_ch.ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            rdy_stall = $urandom_range(1, 80);
                    end
                end
                default: res_ch.ready <= (rdy_tick % 3 == 0);
            endcase
        end
    end

    initial
    begin
        int                   n0;
        int                   reps;
        int                   k;
        int                   c;
        logic [TIME_W-1:0]    gen_now;
        logic [ADDR_W-1:0]    who;
        logic [COUNT_W-1:0]   lim;
        logic [SECONDS_W-1:0] secs;

        rst_n        <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        safe_cnt_q = '0;
        foreach (safe_list[i])
            safe_list[i] = '0;
        limit_q   = LIMIT_RESET;
        ban_len_q = BAN_SECONDS_RESET;
        foreach (bt_used[i])
            bt_used[i] = 1'b0;
        foreach (addr_pool[i])
            addr_pool[i] = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings
        queue_attempt(32'h0000_0000, 32'h0000_0000, 16'h0000); // address 0 not on empty list
        queue_attempt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF); // expiry saturates
        queue_attempt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000); // expiry equals now: lapsed
        queue_attempt(32'h0A00_0001, 32'd100, 16'd20);         // count at limit
        queue_attempt(32'h0A00_0001, 32'd399, 16'd0);          // still banned
        queue_attempt(32'h0A00_0001, 32'd400, 16'd25);         // lapsed, rebanned in same slot
        queue_attempt(32'h0A00_0002, 32'd400, 16'd19);         // one below limit
        wait_idle();

        // zero limit and zero ban length: every count bans, and a ban made at time 0 never lapses
        write_reg(REG_LIMIT, 32'd0);
        write_reg(REG_BAN_SECONDS, 32'd0);
        config_sets++;
        queue_attempt(32'h1234_5678, 32'h0000_0000, 16'h0000);
        queue_attempt(32'h1234_5678, 32'hFFFF_FFFF, 16'h0000);
        queue_attempt(32'h0B00_0001, 32'd5, 16'd0);
        queue_attempt(32'h0B00_0001, 32'd5, 16'd0);
        wait_idle();

        // oversized safe count, top limit and ban length, unmapped index
        write_reg(REG_SAFE_COUNT, 32'd7);
        write_reg(REG_SAFE_ADDR_A, 32'h0000_0000);
        write_reg(REG_SAFE_ADDR_B, 32'hFFFF_FFFF);
        write_reg(REG_SAFE_ADDR_C, 32'h1234_5678);
        write_reg(REG_SAFE_ADDR_D, 32'hC0A8_0001);
        write_reg(REG_LIMIT, 32'h0000_FFFF);
        write_reg(REG_BAN_SECONDS, 32'h0000_FFFF);
        write_reg(REG_NONE, 32'hDEAD_BEEF);
        config_sets++;
        queue_attempt(32'h0000_0000, 32'd900, 16'hFFFF);
        queue_attempt(32'hFFFF_FFFF, 32'd900, 16'hFFFF);
        queue_attempt(32'h1234_5678, 32'd900, 16'hFFFF);       // safe wins over a ban
        queue_attempt(32'hC0A8_0001, 32'd900, 16'hFFFF);
        queue_attempt(32'h0A00_00FF, 32'd1000, 16'hFFFF);
        queue_attempt(32'h0A00_00FE, 32'd1000, 16'hFFFE);
        wait_idle();

        write_reg(REG_SAFE_COUNT, 32'd2);
        config_sets++;
        queue_attempt(32'h1234_5678, 32'd7, 16'd0);
        queue_attempt(32'hC0A8_0001, 32'd7, 16'd0);

        gen_now = $urandom_range(0, 1000);
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            config_sets++;
            if (ph == 4)
            begin
                // flood distinct addresses to overrun the table
                write_reg(REG_SAFE_COUNT, 32'd0);
                write_reg(REG_LIMIT, {16'($urandom), 16'd0});
                write_reg(REG_BAN_SECONDS, {16'($urandom), 16'hFFFF});
                for (int i = 0; i < 80; i++)
                    queue_attempt(addr_pool[i], gen_now + i / 8, 16'($urandom));
                for (int i = 0; i < 20; i++)
                    queue_attempt(addr_pool[$urandom_range(0, POOL_SIZE - 1)], gen_now + 10,
                                  16'($urandom));
                gen_now += 70000;
                continue;
            end
            write_reg(REG_SAFE_COUNT, $urandom);
            write_reg(REG_SAFE_ADDR_A,
                      $urandom_range(0, 1) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom);
            write_reg(REG_SAFE_ADDR_B,
                      $urandom_range(0, 1) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom);
            write_reg(REG_SAFE_ADDR_C,
                      $urandom_range(0, 1) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom);
            write_reg(REG_SAFE_ADDR_D,
                      $urandom_range(0, 1) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom);
            case ($urandom_range(0, 5))
                0:       lim = 16'd0;
                1:       lim = 16'd1;
                2:       lim = 16'hFFFF;
                default: lim = 16'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 4))
                0:       secs = 16'd0;
                1:       secs = 16'hFFFF;
                default: secs = 16'($urandom_range(1, 600));
            endcase
            write_reg(REG_LIMIT, {16'($urandom), lim});
            write_reg(REG_BAN_SECONDS, {16'($urandom), secs});
            if ($urandom_range(0, 3) == 0)
                gen_now = 32'hFFFF_0000 + $urandom_range(0, 65535);
            n0 = issued_count;
            while (issued_count - n0 < 150)
            begin
                k = $urandom_range(0, 99);
                if (k < 55)
                begin
                    // ban, retries while banned, retry after expiry
                    who  = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                    reps = $urandom_range(2, 5);
                    for (int r = 0; r < reps; r++)
                    begin
                        c = int'(limit_q) + int'($urandom_range(0, 4)) - 2;
                        if (c < 0)
                            c = 0;
                        if (c > 65535)
                            c = 65535;
                        queue_attempt(who, gen_now, c[COUNT_W-1:0]);
                        gen_now += $urandom_range(0, int'(ban_len_q) + 2);
                    end
                end
                else if (k < 70)
                    queue_attempt(safe_list[$urandom_range(0, 3)], gen_now, 16'($urandom));
                else if (k < 85)
                    queue_attempt($urandom, $urandom, 16'($urandom));
                else
                    queue_attempt(addr_pool[$urandom_range(0, POOL_SIZE - 1)], gen_now,
                                  16'($urandom));
                gen_now += $urandom_range(0, 3);
            end
        end

        wait_idle();
        repeat (BAN_ENTRIES_DEF + 10) @(posedge clk);
        $display("Covered %0d connection attempts across %0d register settings.",
                 taken_count, config_sets);
        $display("Decisions: %0d safe, %0d under limit, %0d banned, %0d new bans (%0d full).",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
                 full_seen);
        if (bad_results == 0 && pending_verdicts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
